// ===== design/mpc_pkg.sv =====
// ----------------------------------------------------------------------------
// mpc_pkg: shared types and constants of the map page cache directory
// Fixed field widths of the request and response channels, and the command
// and status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package mpc_pkg;

    localparam int PN_W       = 20;   // page number
    localparam int LOC_OUT_W  = 24;   // flash page location on the ports
    localparam int SLOT_OUT_W = 4;    // slot number on the ports
    localparam int EVMP_W     = 10;   // evicted map page on the ports

    typedef struct packed {
        logic                 req_type;
        logic                 map_kind;
        logic [PN_W-1:0]      page_number;
        logic [LOC_OUT_W-1:0] spare_page;
    } t_req;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  fill_valid;
        logic [LOC_OUT_W-1:0]  fill_location;
        logic                  writeback_valid;
        logic [LOC_OUT_W-1:0]  writeback_location;
        logic                  evicted_valid;
        logic [EVMP_W-1:0]     evicted_map_page;
        logic                  evicted_kind;
        logic                  spare_used;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic clear;      // clearing pass: wipe one directory and home entry
        logic accept;     // capture the request, start the map page divide
        logic div2;       // quotient by entries per map page
        logic div3;       // quotient by map page count times count
        logic rem;        // map page number
        logic page_chk;   // take the directory's slot number
        logic hit_upd;    // hit: set reference, mark dirty on update
        logic sweep;      // one step of the clock hand
        logic vic_chk;    // examine victim, write back if dirty
        logic vic_page;   // drop the victim's directory entry if it is ours
        logic fill;       // install the requested page in the victim slot
        logic finish;     // load the response register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic cached;
        logic match;
        logic hand_ref;
        logic out_busy;
    } t_sts;

endpackage

// ===== design/mpc_req_if.sv =====
// ----------------------------------------------------------------------------
// mpc_req_if: request channel
// Valid/ready channel carrying one directory request.
// ----------------------------------------------------------------------------
interface mpc_req_if;
    logic                           valid;
    logic                           ready;
    logic                           req_type;
    logic                           map_kind;
    logic [mpc_pkg::PN_W-1:0]       page_number;
    logic [mpc_pkg::LOC_OUT_W-1:0]  spare_page;

    modport source (output valid, req_type, map_kind, page_number, spare_page,
                    input ready);
    modport sink   (input valid, req_type, map_kind, page_number, spare_page,
                    output ready);
endinterface

// ===== design/mpc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mpc_rsp_if: response channel
// Valid/ready channel carrying one directory result.
// ----------------------------------------------------------------------------
interface mpc_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic [mpc_pkg::SLOT_OUT_W-1:0]  slot;
    logic                            fill_valid;
    logic [mpc_pkg::LOC_OUT_W-1:0]   fill_location;
    logic                            writeback_valid;
    logic [mpc_pkg::LOC_OUT_W-1:0]   writeback_location;
    logic                            evicted_valid;
    logic [mpc_pkg::EVMP_W-1:0]      evicted_map_page;
    logic                            evicted_kind;
    logic                            spare_used;

    modport source (output valid, hit, slot, fill_valid, fill_location,
                    writeback_valid, writeback_location, evicted_valid,
                    evicted_map_page, evicted_kind, spare_used,
                    input ready);
    modport sink   (input valid, hit, slot, fill_valid, fill_location,
                    writeback_valid, writeback_location, evicted_valid,
                    evicted_map_page, evicted_kind, spare_used,
                    output ready);
endinterface

// ===== design/mpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpc_ctrl: sequencer of the map page cache directory
// Walks each request through divide, directory lookup, hit check if cached,
// then on a miss clock sweep, eviction and fill; one command bundle per cycle.
// ----------------------------------------------------------------------------
module mpc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mpc_pkg::t_sts i_sts,
    output mpc_pkg::t_cmd o_cmd
);

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_DIV2   = 5'd2;
    localparam logic [4:0] S_DIV3   = 5'd3;
    localparam logic [4:0] S_REM    = 5'd4;
    localparam logic [4:0] S_PLOOK  = 5'd5;
    localparam logic [4:0] S_PCHK   = 5'd6;
    localparam logic [4:0] S_MLOOK  = 5'd7;
    localparam logic [4:0] S_HCHK   = 5'd8;
    localparam logic [4:0] S_SWEEP  = 5'd9;
    localparam logic [4:0] S_VLOOK  = 5'd10;
    localparam logic [4:0] S_VCHK   = 5'd11;
    localparam logic [4:0] S_VPLOOK = 5'd12;
    localparam logic [4:0] S_VPCHK  = 5'd13;
    localparam logic [4:0] S_HLOOK  = 5'd14;
    localparam logic [4:0] S_FILL   = 5'd15;
    localparam logic [4:0] S_DONE   = 5'd16;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DIV2;
                end
            end
            S_DIV2: begin
                o_cmd.div2 = 1'b1;
                n_state    = S_DIV3;
            end
            S_DIV3: begin
                o_cmd.div3 = 1'b1;
                n_state    = S_REM;
            end
            S_REM: begin
                o_cmd.rem = 1'b1;
                n_state   = S_PLOOK;
            end
            S_PLOOK: n_state = S_PCHK;
            S_PCHK: begin
                o_cmd.page_chk = 1'b1;
                n_state        = i_sts.cached ? S_MLOOK : S_SWEEP;
            end
            S_MLOOK: n_state = S_HCHK;
            S_HCHK: begin
                if (i_sts.match) begin
                    o_cmd.hit_upd = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                // advance the hand until it passes a slot with a clear reference bit
                o_cmd.sweep = 1'b1;
                if (!i_sts.hand_ref) n_state = S_VLOOK;
            end
            S_VLOOK: n_state = S_VCHK;
            S_VCHK: begin
                o_cmd.vic_chk = 1'b1;
                n_state       = S_VPLOOK;
            end
            S_VPLOOK: n_state = S_VPCHK;
            S_VPCHK: begin
                o_cmd.vic_page = 1'b1;
                n_state        = S_HLOOK;
            end
            S_HLOOK: n_state = S_FILL;
            S_FILL: begin
                o_cmd.fill = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                // hold while the previous result is still stalled
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== design/mpc_dpath.sv =====
// ----------------------------------------------------------------------------
// mpc_dpath: datapath of the map page cache directory
// Map page divider, directory and home location memories, slot tables,
// clock hand and the response register.
// ----------------------------------------------------------------------------
module mpc_dpath #(
    parameter int CACHE_SLOTS          = 16,
    parameter int MAP_PAGES            = 1024,
    parameter int ENTRIES_PER_MAP_PAGE = 1024,
    parameter int LOCATION_BITS        = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mpc_pkg::t_cmd i_cmd,
    output mpc_pkg::t_sts o_sts,
    input  mpc_pkg::t_req i_req,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output mpc_pkg::t_rsp o_rsp
);

    localparam int PN_W   = mpc_pkg::PN_W;
    localparam int SLOT_W = $clog2(CACHE_SLOTS);
    localparam int MP_W   = $clog2(MAP_PAGES);
    localparam int LOC_W  = (LOCATION_BITS < mpc_pkg::LOC_OUT_W) ?
                            LOCATION_BITS : mpc_pkg::LOC_OUT_W;

    // floor(n / d) = (n * ceil(2^s / d)) >> s, s = PN_W + ceil(log2 d)
    localparam int M_W    = PN_W + 2;
    localparam int PROD_W = PN_W + M_W;
    localparam int S1     = PN_W + $clog2(ENTRIES_PER_MAP_PAGE);
    localparam int S2     = PN_W + $clog2(MAP_PAGES);
    localparam logic [63:0] M1_FULL = ((64'd1 << S1) + 64'(ENTRIES_PER_MAP_PAGE) - 64'd1)
                                      / 64'(ENTRIES_PER_MAP_PAGE);
    localparam logic [63:0] M2_FULL = ((64'd1 << S2) + 64'(MAP_PAGES) - 64'd1)
                                      / 64'(MAP_PAGES);
    localparam logic [M_W-1:0]  M1       = M_W'(M1_FULL);
    localparam logic [M_W-1:0]  M2       = M_W'(M2_FULL);
    localparam logic [MP_W:0]   MP_CONST = (MP_W + 1)'(MAP_PAGES);
    localparam logic [MP_W-1:0] CLR_LAST = MP_W'(MAP_PAGES - 1);
    localparam logic [SLOT_W-1:0] HAND_LAST = SLOT_W'(CACHE_SLOTS - 1);

    // request
    logic             r_upd;
    logic             r_kind;
    logic [LOC_W-1:0] r_spare;

    // divider
    logic [PROD_W-1:0] r_prod1;
    logic [PROD_W-1:0] r_prod2;
    logic [PN_W-1:0]   r_quo;
    logic [PN_W-1:0]   r_prod3;
    logic [PN_W-1:0]   q1;
    logic [PN_W-1:0]   q2;
    logic [MP_W-1:0]   rem;
    logic [MP_W-1:0]   r_mp;

    // directory {cached, slot} and home {known, location}
    logic [SLOT_W:0]   page_mem [MAP_PAGES];
    logic [LOC_W:0]    home_mem [MAP_PAGES];
    logic [SLOT_W:0]   r_page_rd;
    logic [LOC_W:0]    r_home_rd;
    logic [MP_W-1:0]   r_paddr;
    logic [MP_W-1:0]   r_clr;
    logic              page_we;
    logic [MP_W-1:0]   page_wa;
    logic [SLOT_W:0]   page_wd;
    logic              home_we;
    logic [MP_W-1:0]   home_wa;
    logic [LOC_W:0]    home_wd;

    // slot tables
    logic [MP_W:0]            meta_mem [CACHE_SLOTS];
    logic [MP_W:0]            r_meta_rd;
    logic [CACHE_SLOTS-1:0]   r_valid;
    logic [CACHE_SLOTS-1:0]   r_ref;
    logic [CACHE_SLOTS-1:0]   r_dirty;
    logic [SLOT_W-1:0]        r_slot;
    logic [SLOT_W-1:0]        r_hand;
    logic                     meta_kind;
    logic [MP_W-1:0]          meta_mp;
    logic                     vic_valid;
    logic                     vic_dirty;
    logic                     home_known;
    logic                     take_spare;

    // result
    logic             r_hit;
    logic             r_fill_v;
    logic [LOC_W-1:0] r_fill_loc;
    logic             r_wb_v;
    logic             r_ev_v;
    logic [MP_W-1:0]  r_ev_mp;
    logic             r_ev_k;
    logic             r_used;
    logic             r_o_valid;
    mpc_pkg::t_rsp    r_rsp;

    assign q1  = PN_W'(r_prod1 >> S1);
    assign q2  = PN_W'(r_prod2 >> S2);
    assign rem = MP_W'(r_quo - r_prod3);

    assign meta_kind  = r_meta_rd[MP_W];
    assign meta_mp    = r_meta_rd[MP_W-1:0];
    assign vic_valid  = r_valid[r_slot];
    assign vic_dirty  = r_dirty[r_slot];
    assign home_known = r_home_rd[LOC_W];
    assign take_spare = !home_known && !r_used;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_upd   <= i_req.req_type;
            r_kind  <= i_req.map_kind;
            r_spare <= i_req.spare_page[LOC_W-1:0];
            r_prod1 <= PROD_W'(i_req.page_number) * PROD_W'(M1);
        end
        if (i_cmd.div2) begin
            r_quo   <= q1;
            r_prod2 <= PROD_W'(q1) * PROD_W'(M2);
        end
        if (i_cmd.div3) begin
            r_prod3 <= PN_W'(q2 * MP_CONST);
        end
        if (i_cmd.rem) begin
            r_mp <= rem;
        end
    end

    // directory and home write ports
    always_comb begin
        page_we = 1'b0;
        page_wa = r_clr;
        page_wd = '0;
        if (i_cmd.clear) begin
            page_we = 1'b1;
        end else if (i_cmd.vic_page) begin
            // drop the entry only if it still points at the victim slot
            page_wa = r_paddr;
            page_we = r_ev_v && r_page_rd[SLOT_W] && (r_page_rd[SLOT_W-1:0] == r_slot);
        end else if (i_cmd.fill) begin
            page_we = 1'b1;
            page_wa = r_mp;
            page_wd = {1'b1, r_slot};
        end
    end

    always_comb begin
        home_we = 1'b0;
        home_wa = r_clr;
        home_wd = '0;
        if (i_cmd.clear) begin
            home_we = 1'b1;
        end else if (i_cmd.vic_chk) begin
            home_we = vic_valid && vic_dirty;
            home_wa = meta_mp;
            home_wd = {1'b1, r_spare};
        end else if (i_cmd.fill) begin
            home_we = take_spare;
            home_wa = r_mp;
            home_wd = {1'b1, r_spare};
        end
    end

    always_ff @(posedge i_clk) begin
        if (page_we) page_mem[page_wa] <= page_wd;
        r_page_rd <= page_mem[r_paddr];
    end

    always_ff @(posedge i_clk) begin
        if (home_we) home_mem[home_wa] <= home_wd;
        r_home_rd <= home_mem[r_paddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill) meta_mem[r_slot] <= {r_kind, r_mp};
        r_meta_rd <= meta_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rem) begin
            r_paddr <= rem;
        end else if (i_cmd.vic_chk) begin
            r_paddr <= meta_mp;
        end else if (i_cmd.vic_page) begin
            r_paddr <= r_mp;
        end
        if (i_cmd.page_chk) begin
            r_slot <= r_page_rd[SLOT_W-1:0];
        end else if (i_cmd.sweep && !r_ref[r_hand]) begin
            r_slot <= r_hand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_hand  <= '0;
            r_valid <= '0;
            r_ref   <= '0;
            r_dirty <= '0;
        end else begin
            if (i_cmd.clear) r_clr <= r_clr + 1'b1;
            if (i_cmd.sweep) begin
                if (r_ref[r_hand]) r_ref[r_hand] <= 1'b0;
                r_hand <= (r_hand == HAND_LAST) ? '0 : r_hand + 1'b1;
            end
            if (i_cmd.hit_upd) begin
                r_ref[r_slot] <= 1'b1;
                if (r_upd) r_dirty[r_slot] <= 1'b1;
            end
            if (i_cmd.fill) begin
                r_valid[r_slot] <= 1'b1;
                r_ref[r_slot]   <= 1'b1;
                r_dirty[r_slot] <= r_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_hit      <= 1'b0;
            r_fill_v   <= 1'b0;
            r_fill_loc <= '0;
            r_wb_v     <= 1'b0;
            r_ev_v     <= 1'b0;
            r_ev_mp    <= '0;
            r_ev_k     <= 1'b0;
            r_used     <= 1'b0;
        end
        if (i_cmd.hit_upd) r_hit <= 1'b1;
        if (i_cmd.vic_chk) begin
            r_ev_v  <= vic_valid;
            r_ev_mp <= vic_valid ? meta_mp : '0;
            r_ev_k  <= vic_valid && meta_kind;
            if (vic_valid && vic_dirty) begin
                r_wb_v <= 1'b1;
                r_used <= 1'b1;
            end
        end
        if (i_cmd.fill) begin
            // an unknown home takes the spare unless writeback consumed it
            r_fill_v   <= home_known || take_spare;
            r_fill_loc <= home_known ? r_home_rd[LOC_W-1:0] :
                          (take_spare ? r_spare : '0);
            if (take_spare) r_used <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_rsp.hit                <= r_hit;
            r_rsp.slot               <= mpc_pkg::SLOT_OUT_W'(r_slot);
            r_rsp.fill_valid         <= r_fill_v;
            r_rsp.fill_location      <= mpc_pkg::LOC_OUT_W'(r_fill_loc);
            r_rsp.writeback_valid    <= r_wb_v;
            r_rsp.writeback_location <= r_wb_v ? mpc_pkg::LOC_OUT_W'(r_spare) : '0;
            r_rsp.evicted_valid      <= r_ev_v;
            r_rsp.evicted_map_page   <= mpc_pkg::EVMP_W'(r_ev_mp);
            r_rsp.evicted_kind       <= r_ev_k;
            r_rsp.spare_used         <= r_used;
        end
    end

    assign o_sts.clr_done = (r_clr == CLR_LAST);
    assign o_sts.cached   = r_page_rd[SLOT_W];
    assign o_sts.match    = vic_valid && (meta_kind == r_kind) && (meta_mp == r_mp);
    assign o_sts.hand_ref = r_ref[r_hand];
    assign o_sts.out_busy = r_o_valid && !i_out_ready;

    assign o_out_valid = r_o_valid;
    assign o_rsp       = r_rsp;

endmodule

// ===== design/map_page_cache_clock.sv =====
// ----------------------------------------------------------------------------
// map_page_cache_clock: map page cache directory with clock replacement
// Top level: request and response channels, sequencer and datapath.
// ----------------------------------------------------------------------------
// One request is in work at a time. After reset a clearing pass wipes the
// directory and home location tables, one entry a cycle, through all
// MAP_PAGES entries; no request is taken during it. A hit passes through the
// reciprocal divide to the map page, then one directory read and one slot
// table read, each with a registered memory port. A miss whose directory
// entry points at a slot holding another page makes the same reads; a miss
// with no directory entry skips the slot table read. Either miss then steps
// the clock hand one slot per cycle, from 1 to CACHE_SLOTS + 1 steps, and
// reads the victim slot, the directory at the victim's map page and the
// home location at the requested map page. A finished result waits in the
// response register while the next request is accepted; the block holds
// before loading a new result until it is taken.
module map_page_cache_clock #(
    parameter int CACHE_SLOTS          = 16,
    parameter int MAP_PAGES            = 1024,
    parameter int ENTRIES_PER_MAP_PAGE = 1024,
    parameter int LOCATION_BITS        = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mpc_req_if.sink   i_req,
    mpc_rsp_if.source o_rsp
);

    mpc_pkg::t_cmd cmd;
    mpc_pkg::t_sts sts;
    mpc_pkg::t_req req;
    mpc_pkg::t_rsp rsp;
    logic          in_ready;
    logic          out_valid;

    assign req.req_type    = i_req.req_type;
    assign req.map_kind    = i_req.map_kind;
    assign req.page_number = i_req.page_number;
    assign req.spare_page  = i_req.spare_page;
    assign i_req.ready     = in_ready;

    mpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mpc_dpath #(
        .CACHE_SLOTS          (CACHE_SLOTS),
        .MAP_PAGES            (MAP_PAGES),
        .ENTRIES_PER_MAP_PAGE (ENTRIES_PER_MAP_PAGE),
        .LOCATION_BITS        (LOCATION_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (req),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (out_valid),
        .o_rsp       (rsp)
    );

    assign o_rsp.valid              = out_valid;
    assign o_rsp.hit                = rsp.hit;
    assign o_rsp.slot               = rsp.slot;
    assign o_rsp.fill_valid         = rsp.fill_valid;
    assign o_rsp.fill_location      = rsp.fill_location;
    assign o_rsp.writeback_valid    = rsp.writeback_valid;
    assign o_rsp.writeback_location = rsp.writeback_location;
    assign o_rsp.evicted_valid      = rsp.evicted_valid;
    assign o_rsp.evicted_map_page   = rsp.evicted_map_page;
    assign o_rsp.evicted_kind       = rsp.evicted_kind;
    assign o_rsp.spare_used         = rsp.spare_used;

    // never overwrite a result that is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> !(o_rsp.valid && !o_rsp.ready))
        else $error("result loaded over a stalled transfer");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> o_rsp.valid)
        else $error("loaded result not offered");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |-> !i_req.ready)
        else $error("request taken during the clearing pass");

    a_hit_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.hit) |-> (!o_rsp.fill_valid && !o_rsp.writeback_valid
                                         && !o_rsp.evicted_valid && !o_rsp.spare_used))
        else $error("hit result carries miss side effects");

    a_wb_spare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.writeback_valid) |-> (o_rsp.spare_used && o_rsp.evicted_valid))
        else $error("writeback without an evicted page or spare");

endmodule
